// ===== rtl/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// utt_pkg
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
// ----------------------------------------------------------------------------
package utt_pkg;

  localparam logic [15:0] REPLACEMENT     = 16'hFFFD;
  localparam logic [15:0] HIGH_SURR       = 16'hD800;
  localparam logic [15:0] LOW_SURR        = 16'hDC00;
  localparam logic [15:0] SURR_TEST_MASK  = 16'hF800;
  localparam logic [20:0] SUPP_BASE       = 21'h010000;
  localparam logic [20:0] LAST_CODE_POINT = 21'h10FFFF;
  localparam logic [20:0] MIN_CP_LEN2     = 21'h000080;
  localparam logic [20:0] MIN_CP_LEN3     = 21'h000800;
  localparam logic [2:0]  SEQ_LEN2        = 3'd2;
  localparam logic [2:0]  SEQ_LEN3        = 3'd3;
  localparam logic [2:0]  SEQ_LEN4        = 3'd4;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // One accepted input byte, held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // Results of one byte: up to two code units, each with its last flag.
  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] unit0;
    logic        last0;
    logic [15:0] unit1;
    logic        last1;
  } result_t;

endpackage

// ===== rtl/utt_in_stage.sv =====
// ----------------------------------------------------------------------------
// utt_in_stage
// Input register: holds one byte until the decoder can hand its results on.
// ----------------------------------------------------------------------------
module utt_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // in_byte
  input  logic              in_tlast,   // in_last
  input  logic              room,
  output utt_pkg::in_item_t item,
  output logic              advance
);
  import utt_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;

  assign advance   = valid_r && room;
  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign item = '{valid: valid_r, data: data_r, last: last_r};

endmodule

// ===== rtl/utt_decoder.sv =====
// ----------------------------------------------------------------------------
// utt_decoder
// Sequence state and the single-pass decode of one byte into code units.
// ----------------------------------------------------------------------------
module utt_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  utt_pkg::in_item_t item,
  input  logic              advance,
  output utt_pkg::result_t  result
);
  import utt_pkg::*;

  typedef struct packed {
    logic        emit;
    logic [15:0] unit;
    logic        open;
    logic [20:0] acc;
    logic [2:0]  len;
    logic [1:0]  pend;
  } lead_t;

  logic [1:0]  pend_r, pend_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [20:0] acc_r, acc_nxt;

  lead_t       lead;
  logic [20:0] acc_ext;
  logic [1:0]  pend_dec;
  logic [19:0] supp;
  logic        bad;
  logic [1:0]  n;
  logic [15:0] u0, u1;

  function automatic lead_t take_lead(input logic [7:0] b, input logic last);
    lead_t      l;
    logic [2:0] ones;
    logic [7:0] masked;
    begin
      if (!b[7])      ones = 3'd0;
      else if (!b[6]) ones = 3'd1;
      else if (!b[5]) ones = 3'd2;
      else if (!b[4]) ones = 3'd3;
      else if (!b[3]) ones = 3'd4;
      else            ones = 3'd5;
      masked = b & (8'h7F >> ones);
      l = '0;
      if (ones == 3'd0) begin
        l.emit = 1'b1;
        l.unit = {8'h00, b};
      end else if (ones == 3'd1 || ones > SEQ_LEN4 || last) begin
        l.emit = 1'b1;
        l.unit = REPLACEMENT;
      end else begin
        l.open = 1'b1;
        l.acc  = {13'd0, masked};
        l.len  = ones;
        l.pend = 2'(ones - 3'd1);
      end
      return l;
    end
  endfunction

  always_comb begin
    lead     = take_lead(item.data, item.last);
    acc_ext  = {acc_r[14:0], item.data[5:0]};
    pend_dec = pend_r - 2'd1;
    supp     = 20'(acc_ext - SUPP_BASE);
    case (len_r)
      SEQ_LEN2: bad = acc_ext < MIN_CP_LEN2;
      SEQ_LEN3: bad = acc_ext < MIN_CP_LEN3 ||
                      (acc_ext[15:0] & SURR_TEST_MASK) == HIGH_SURR;
      default:  bad = acc_ext < SUPP_BASE || acc_ext > LAST_CODE_POINT;
    endcase

    n        = 2'd0;
    u0       = REPLACEMENT;
    u1       = REPLACEMENT;
    pend_nxt = 2'd0;
    len_nxt  = 3'd0;
    acc_nxt  = '0;

    if (pend_r != 2'd0) begin
      if (item.data[7:6] == 2'b10) begin
        if (pend_dec == 2'd0) begin
          n = 2'd1;
          if (!bad && acc_ext < SUPP_BASE) begin
            u0 = acc_ext[15:0];
          end else if (!bad) begin
            // Supplementary plane: high surrogate first, then low.
            n  = 2'd2;
            u0 = HIGH_SURR | {6'd0, supp[19:10]};
            u1 = LOW_SURR | {6'd0, supp[9:0]};
          end
        end else if (item.last) begin
          n = 2'd1;
        end else begin
          pend_nxt = pend_dec;
          len_nxt  = len_r;
          acc_nxt  = acc_ext;
        end
      end else begin
        // Cut sequence: replacement, then the byte is taken as a new lead.
        n  = lead.emit ? 2'd2 : 2'd1;
        u1 = lead.unit;
        if (lead.open) begin
          pend_nxt = lead.pend;
          len_nxt  = lead.len;
          acc_nxt  = lead.acc;
        end
      end
    end else begin
      n  = {1'b0, lead.emit};
      u0 = lead.unit;
      if (lead.open) begin
        pend_nxt = lead.pend;
        len_nxt  = lead.len;
        acc_nxt  = lead.acc;
      end
    end

    if (item.last) begin
      pend_nxt = 2'd0;
      len_nxt  = 3'd0;
      acc_nxt  = '0;
    end

    result = '{count: n, unit0: u0, last0: item.last && n == 2'd1,
               unit1: u1, last1: item.last && n == 2'd2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      len_r  <= 3'd0;
      acc_r  <= '0;
    end else if (advance) begin
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
    end
  end

  a_open_len : assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd0 |-> (len_r == SEQ_LEN2 || len_r == SEQ_LEN3 || len_r == SEQ_LEN4))
    else $error("open sequence with a bad length");

  a_pend_below_len : assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd0 |-> {1'b0, pend_r} < len_r)
    else $error("more continuation bytes pending than the sequence holds");

  a_last_idle : assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.last |=> pend_r == 2'd0)
    else $error("decoder not idle after the final byte");

  a_last_emits : assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.last |-> result.count != 2'd0)
    else $error("final byte produced no code unit");

endmodule

// ===== rtl/utt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// utt_out_fifo
// Result queue, per cycle: up to two units in, one out on out_tready.
// ----------------------------------------------------------------------------
module utt_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  utt_pkg::result_t result,
  input  logic             push,
  output logic             room,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,   // utf16_unit
  output logic             out_tlast    // out_last
);
  import utt_pkg::*;

  logic [16:0]      mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;
  logic [1:0]       push_n;

  // Room for a full pair regardless of this cycle's read.
  assign room       = count_r <= CNT_W'(FIFO_DEPTH - 2);
  assign out_tvalid = count_r != '0;
  assign pop        = out_tvalid && out_tready;
  assign push_n     = push ? result.count : 2'd0;
  assign out_tdata  = mem_r[rd_ptr_r][16:1];
  assign out_tlast  = mem_r[rd_ptr_r][0];

  always_comb begin
    count_nxt = count_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= {result.unit0, result.last0};
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= {result.unit1, result.last1};
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room)
    else $error("results pushed without room for a pair");

  a_ptr_span : assert property (@(posedge clk) disable iff (!rst_n)
    count_r != CNT_W'(FIFO_DEPTH) |->
      PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(count_r))
    else $error("queue pointers disagree with the fill count");

endmodule

// ===== rtl/utf8_to_utf16_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code unit stream out.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle while its result queue has room
// and gives UTF-16 code units, with 0xFFFD in place of every invalid
// sequence and a surrogate pair for code points of 0x10000 and above. A byte
// goes into the input register, is decoded from there and its units are
// written to a four-entry result queue that drives out_tdata. The output side
// gives one unit per cycle while out_tready is high, so input runs at one
// byte per cycle as long as the text averages no more than one unit per
// byte; a burst of two-unit results (a cut sequence followed by a byte that
// makes a unit of its own) makes the queue fill and holds in_tready low
// until there is room for a pair. out_tlast is set on the final unit
// produced by the byte that carried in_tlast; the decoder is idle after it.
module utf8_to_utf16_transcoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // in_byte
  input  logic        in_tlast,    // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // utf16_unit
  output logic        out_tlast    // out_last
);
  import utt_pkg::*;

  in_item_t item;
  result_t  result;
  logic     advance;
  logic     room;

  utt_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .room      (room),
    .item      (item),
    .advance   (advance)
  );

  utt_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  utt_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .result     (result),
    .push       (advance),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
